// ===== src/ppt_pkg.sv =====
// Package for the pure pursuit target finder: sizes, codes, record types and
// small helper functions. No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package ppt_pkg;

  localparam int MAX_WP     = 64;
  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int HEAD_BITS  = 20;
  localparam int RAD_W      = COORD_BITS - 1;
  localparam int HTOL_W     = HEAD_BITS - 1;
  localparam int ADDR_W     = $clog2(MAX_WP);
  localparam int CNT_W      = ADDR_W + 1;

  localparam int DW      = COORD_BITS + 1;
  localparam int MUL_W   = DW + 1;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int NUM_W   = 2 * DW;
  localparam int ROOT_W  = DW;
  localparam int REM_W   = ROOT_W + 3;
  localparam int STEP_W  = $clog2(NUM_W + 1);

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [RAD_W-1:0]  RAD_RESET  = RAD_W'(1 << FRAC_BITS);
  localparam logic [RAD_W-1:0]  PTOL_RESET = RAD_W'(((1 << FRAC_BITS) * 5 + 50) / 100);
  localparam logic [HTOL_W-1:0] HTOL_RESET = HTOL_W'(((1 << FRAC_BITS) * 5 + 50) / 100);

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_RSVD   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_PTOL   = 2'd1;
  localparam logic [1:0] REG_HTOL   = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [HEAD_BITS-1:0]  h;
    logic                         turn;
  } wp_t;

  typedef struct packed {
    logic              start;
    logic              sqrt_mode;
    logic [NUM_W-1:0]  num;
    logic [ROOT_W-1:0] den;
  } ds_req_t;

  function automatic logic [NUM_W-1:0] mag(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] a;
    a = v[PROD_W-1] ? -v : v;
    return a[NUM_W-1:0];
  endfunction

  function automatic logic signed [MUL_W-1:0] sx(input logic signed [DW-1:0] v);
    return {v[DW-1], v};
  endfunction

endpackage

// ===== src/ppt_wp_mem.sv =====
// Waypoint ring store: one write port and one registered read port.
// Depends on ppt_pkg for the entry record and the depth.
`timescale 1ns / 1ps
module ppt_wp_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [ppt_pkg::ADDR_W-1:0] waddr,
  input  ppt_pkg::wp_t              wdata,
  input  logic [ppt_pkg::ADDR_W-1:0] raddr,
  output ppt_pkg::wp_t              rdata
);

  ppt_pkg::wp_t mem [ppt_pkg::MAX_WP];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/ppt_divsqrt.sv =====
// Shared iterative unit: restoring unsigned divide, one quotient bit a cycle,
// or integer square root, one root bit a cycle. Depends on ppt_pkg.
`timescale 1ns / 1ps
module ppt_divsqrt (
  input  logic                     clk,
  input  logic                     rst,
  input  ppt_pkg::ds_req_t         req,
  output logic                     done,
  output logic [ppt_pkg::NUM_W-1:0] res
);

  logic                        busy;
  logic                        mode;
  logic [ppt_pkg::NUM_W-1:0]   acc;
  logic [ppt_pkg::ROOT_W-1:0]  den;
  logic [ppt_pkg::ROOT_W-1:0]  root;
  logic [ppt_pkg::REM_W-1:0]   rem;
  logic [ppt_pkg::STEP_W-1:0]  step;
  logic [ppt_pkg::REM_W-1:0]   sh;
  logic [ppt_pkg::REM_W-1:0]   trial;
  logic                        ge;

  always_comb begin
    if (mode) begin
      sh    = {rem[ppt_pkg::REM_W-3:0], acc[ppt_pkg::NUM_W-1:ppt_pkg::NUM_W-2]};
      trial = {1'b0, root, 2'b01};
    end else begin
      sh    = {rem[ppt_pkg::REM_W-2:0], acc[ppt_pkg::NUM_W-1]};
      trial = ppt_pkg::REM_W'(den);
    end
    ge  = (sh >= trial);
    res = mode ? ppt_pkg::NUM_W'(root) : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        mode <= req.sqrt_mode;
        acc  <= req.num;
        den  <= req.den;
        rem  <= '0;
        root <= '0;
        step <= req.sqrt_mode ? ppt_pkg::STEP_W'(ppt_pkg::NUM_W / 2)
                              : ppt_pkg::STEP_W'(ppt_pkg::NUM_W);
      end else if (busy) begin
        rem <= ge ? (sh - trial) : sh;
        if (mode) begin
          acc  <= {acc[ppt_pkg::NUM_W-3:0], 2'b00};
          root <= {root[ppt_pkg::ROOT_W-2:0], ge};
        end else begin
          acc <= {acc[ppt_pkg::NUM_W-2:0], ge};
        end
        step <= step - 1'b1;
        if (step == ppt_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== src/pure_pursuit_target_finder_top.sv =====
// Top level of the pure pursuit target finder: APB registers, sequencer,
// shared multiplier. Depends on ppt_pkg, ppt_wp_mem and ppt_divsqrt.
//
//   channel  signals                         payload
//   request  in_valid / in_ready             opcode pos_x pos_y heading is_turn drop_passed
//   result   out_valid / out_ready           target_x target_y target_found at_goal
//                                            status waypoint_count
//   config   psel penable pwrite paddr ...   pwdata / prdata
//
// Load, append and reserved requests pass from idle straight to the result stage. A query
// walks the path segment by segment through the shared divide and square root unit (up to
// four divides and two roots per segment); a query that ends on the final point skips the
// segment walk.
// Reset clears the queue, the registers and the sequencer; the store is not cleared.
// in_ready is low while a request is in work; a finished result waits in the output
// register, and the next result holds until it is taken.
`timescale 1ns / 1ps
module pure_pursuit_target_finder_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           opcode,
  input  logic signed [ppt_pkg::COORD_BITS-1:0] pos_x,
  input  logic signed [ppt_pkg::COORD_BITS-1:0] pos_y,
  input  logic signed [ppt_pkg::HEAD_BITS-1:0]  heading,
  input  logic                                 is_turn,
  input  logic                                 drop_passed,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [ppt_pkg::COORD_BITS-1:0] target_x,
  output logic signed [ppt_pkg::COORD_BITS-1:0] target_y,
  output logic                                 target_found,
  output logic                                 at_goal,
  output logic [1:0]                           status,
  output logic [ppt_pkg::CNT_W-1:0]            waypoint_count,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [ppt_pkg::PADDR_W-1:0]          paddr,
  input  logic [ppt_pkg::PDATA_W-1:0]          pwdata,
  output logic [ppt_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready
);

  typedef enum logic [5:0] {
    S_IDLE, S_FRD, S_FCAP, S_E1, S_E2, S_E3, S_E4,
    S_SEG, S_P1W, S_P1C, S_P2C, S_A1, S_A2, S_A3, S_A4, S_LEN,
    S_D1, S_D2, S_D3, S_D4, S_D5, S_DIST, S_DT1, S_DT2, S_LL, S_S0,
    S_X1, S_X2, S_XQ, S_Y1, S_Y2, S_YQ, S_NEXT, S_DROP, S_FIN
  } state_t;

  state_t state;

  logic [ppt_pkg::RAD_W-1:0]  r_rad;
  logic [ppt_pkg::RAD_W-1:0]  r_ptol;
  logic [ppt_pkg::HTOL_W-1:0] r_htol;

  logic [ppt_pkg::ADDR_W-1:0] head;
  logic [ppt_pkg::CNT_W-1:0]  cnt;
  logic [ppt_pkg::CNT_W-1:0]  seg_i;
  logic [ppt_pkg::ADDR_W-1:0] chosen;
  logic                       hit;
  logic [ppt_pkg::ADDR_W-1:0] rd_addr;

  logic signed [ppt_pkg::COORD_BITS-1:0] px, py;
  logic signed [ppt_pkg::HEAD_BITS-1:0]  ph;
  logic                                  drop;
  ppt_pkg::wp_t                          fin;
  logic                                  goal_en;

  logic signed [ppt_pkg::DW-1:0]     x1, y1, dx, dy;
  logic [ppt_pkg::ROOT_W-1:0]        len;
  logic [ppt_pkg::RAD_W-1:0]         perp, ll;
  logic [ppt_pkg::ROOT_W-1:0]        s;
  logic signed [ppt_pkg::PROD_W-1:0] acc, dot, r2;
  logic signed [ppt_pkg::COORD_BITS-1:0] hx;
  logic                              negq;

  logic signed [ppt_pkg::COORD_BITS-1:0] res_x, res_y;
  logic                                  res_found;
  logic [1:0]                            res_status;

  logic signed [ppt_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [ppt_pkg::PROD_W-1:0] prod;

  ppt_pkg::ds_req_t               ds_req;
  logic                           ds_done;
  logic [ppt_pkg::NUM_W-1:0]      ds_res;

  logic                           mem_we;
  logic [ppt_pkg::ADDR_W-1:0]     mem_waddr;
  ppt_pkg::wp_t                   mem_wdata;
  ppt_pkg::wp_t                   mem_rdata;

  logic                           accept;
  logic                           cfg_we;
  logic [ppt_pkg::CNT_W-1:0]      cnt_m1;
  logic signed [ppt_pkg::DW-1:0]  pxe, pye, ex, ey, fx, fy, gx, gy;
  logic signed [ppt_pkg::HEAD_BITS:0] gh;
  logic [ppt_pkg::DW-1:0]         gxa, gya;
  logic [ppt_pkg::HEAD_BITS:0]    gha;
  logic                           goal;
  logic signed [ppt_pkg::PROD_W-1:0] crv, s0, sa, sb, lenx;
  logic                           ok_a, ok_b;
  logic signed [ppt_pkg::DW:0]    hsum;
  logic [ppt_pkg::DW:0]           qx;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign accept = in_valid & in_ready;
  assign in_ready = (state == S_IDLE);
  assign cnt_m1 = cnt - 1'b1;

  always_comb begin
    case (paddr[3:2])
      ppt_pkg::REG_RADIUS: prdata = ppt_pkg::PDATA_W'(r_rad);
      ppt_pkg::REG_PTOL:   prdata = ppt_pkg::PDATA_W'(r_ptol);
      ppt_pkg::REG_HTOL:   prdata = ppt_pkg::PDATA_W'(r_htol);
      default:             prdata = '0;
    endcase
  end

  assign mem_wdata = '{x: pos_x, y: pos_y, h: heading, turn: is_turn};
  assign mem_we    = accept && ((opcode == ppt_pkg::OP_LOAD) ||
                     (opcode == ppt_pkg::OP_APPEND && cnt < ppt_pkg::CNT_W'(ppt_pkg::MAX_WP)));
  assign mem_waddr = (opcode == ppt_pkg::OP_LOAD) ? '0 : head + cnt[ppt_pkg::ADDR_W-1:0];

  ppt_wp_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  ppt_divsqrt u_ds (
    .clk  (clk),
    .rst  (rst),
    .req  (ds_req),
    .done (ds_done),
    .res  (ds_res)
  );

  always_comb begin
    pxe  = {px[ppt_pkg::COORD_BITS-1], px};
    pye  = {py[ppt_pkg::COORD_BITS-1], py};
    ex   = pxe - {fin.x[ppt_pkg::COORD_BITS-1], fin.x};
    ey   = pye - {fin.y[ppt_pkg::COORD_BITS-1], fin.y};
    fx   = x1 - pxe;
    fy   = y1 - pye;
    gx   = -ex;
    gy   = -ey;
    gxa  = gx[ppt_pkg::DW-1] ? -gx : gx;
    gya  = gy[ppt_pkg::DW-1] ? -gy : gy;
    gh   = {fin.h[ppt_pkg::HEAD_BITS-1], fin.h} - {ph[ppt_pkg::HEAD_BITS-1], ph};
    gha  = gh[ppt_pkg::HEAD_BITS] ? -gh : gh;
    goal = goal_en && (gxa < ppt_pkg::DW'(r_ptol)) && (gya < ppt_pkg::DW'(r_ptol)) &&
           (!fin.turn || gha < (ppt_pkg::HEAD_BITS + 1)'(r_htol));
    crv  = acc - prod;
    lenx = ppt_pkg::PROD_W'(len);
    s0   = dot[ppt_pkg::PROD_W-1] ? ppt_pkg::PROD_W'(ds_res) : -ppt_pkg::PROD_W'(ds_res);
    sa   = s0 + ppt_pkg::PROD_W'(ll);
    sb   = s0 - ppt_pkg::PROD_W'(ll);
    ok_a = !sa[ppt_pkg::PROD_W-1] && (sa <= lenx);
    ok_b = !sb[ppt_pkg::PROD_W-1] && (sb <= lenx);
    qx   = {1'b0, ds_res[ppt_pkg::DW-1:0]};
    hsum = (negq ? -$signed(qx) : $signed(qx));
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_E1:  begin mul_a = ppt_pkg::sx(ex); mul_b = ppt_pkg::sx(ex); end
      S_E2:  begin mul_a = ppt_pkg::sx(ey); mul_b = ppt_pkg::sx(ey); end
      S_E3: begin
        mul_a = ppt_pkg::MUL_W'(r_rad);
        mul_b = ppt_pkg::MUL_W'(r_rad);
      end
      S_A1:  begin mul_a = ppt_pkg::sx(dx); mul_b = ppt_pkg::sx(dx); end
      S_A2:  begin mul_a = ppt_pkg::sx(dy); mul_b = ppt_pkg::sx(dy); end
      S_D1:  begin mul_a = ppt_pkg::sx(fx); mul_b = ppt_pkg::sx(dx); end
      S_D2:  begin mul_a = ppt_pkg::sx(fy); mul_b = ppt_pkg::sx(dy); end
      S_D3:  begin mul_a = ppt_pkg::sx(fx); mul_b = ppt_pkg::sx(dy); end
      S_D4:  begin mul_a = ppt_pkg::sx(fy); mul_b = ppt_pkg::sx(dx); end
      S_DT1: begin
        mul_a = ppt_pkg::MUL_W'(perp);
        mul_b = ppt_pkg::MUL_W'(perp);
      end
      S_X1:  begin mul_a = ppt_pkg::sx(dx); mul_b = ppt_pkg::MUL_W'(s); end
      S_Y1:  begin mul_a = ppt_pkg::sx(dy); mul_b = ppt_pkg::MUL_W'(s); end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  always_comb begin
    ds_req = '{start: 1'b0, sqrt_mode: 1'b0, num: '0, den: len};
    case (state)
      S_A4: begin
        ds_req.start     = (acc != '0);
        ds_req.sqrt_mode = 1'b1;
        ds_req.num       = acc[ppt_pkg::NUM_W-1:0];
      end
      S_D5: begin
        ds_req.start = 1'b1;
        ds_req.num   = ppt_pkg::mag(crv);
      end
      S_DT2: begin
        ds_req.start     = 1'b1;
        ds_req.sqrt_mode = 1'b1;
        ds_req.num       = ppt_pkg::NUM_W'(r2 - prod);
      end
      S_LL: begin
        ds_req.start = ds_done;
        ds_req.num   = ppt_pkg::mag(dot);
      end
      S_X2, S_Y2: begin
        ds_req.start = 1'b1;
        ds_req.num   = ppt_pkg::mag(prod);
      end
      default: begin
        ds_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
      r_rad     <= ppt_pkg::RAD_RESET;
      r_ptol    <= ppt_pkg::PTOL_RESET;
      r_htol    <= ppt_pkg::HTOL_RESET;
    end else begin
      if (cfg_we) begin
        case (paddr[3:2])
          ppt_pkg::REG_RADIUS: r_rad  <= pwdata[ppt_pkg::RAD_W-1:0];
          ppt_pkg::REG_PTOL:   r_ptol <= pwdata[ppt_pkg::RAD_W-1:0];
          ppt_pkg::REG_HTOL:   r_htol <= pwdata[ppt_pkg::HTOL_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            px         <= pos_x;
            py         <= pos_y;
            ph         <= heading;
            drop       <= drop_passed;
            res_x      <= '0;
            res_y      <= '0;
            res_found  <= 1'b0;
            res_status <= ppt_pkg::ST_OK;
            goal_en    <= 1'b0;
            state      <= S_FIN;
            case (opcode)
              ppt_pkg::OP_LOAD: begin
                head <= '0;
                cnt  <= ppt_pkg::CNT_W'(1);
              end
              ppt_pkg::OP_APPEND: begin
                if (cnt >= ppt_pkg::CNT_W'(ppt_pkg::MAX_WP)) begin
                  res_status <= ppt_pkg::ST_FULL;
                end else begin
                  cnt <= cnt + 1'b1;
                end
              end
              ppt_pkg::OP_QUERY: begin
                if (cnt == '0) begin
                  res_status <= ppt_pkg::ST_EMPTY;
                end else begin
                  rd_addr <= head + cnt_m1[ppt_pkg::ADDR_W-1:0];
                  state   <= S_FRD;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_FRD:  state <= S_FCAP;
        S_FCAP: begin
          fin     <= mem_rdata;
          goal_en <= 1'b1;
          state   <= S_E1;
        end
        S_E1: state <= S_E2;
        S_E2: begin
          acc   <= prod;
          state <= S_E3;
        end
        S_E3: begin
          acc   <= acc + prod;
          state <= S_E4;
        end
        S_E4: begin
          r2 <= prod;
          if (acc < prod) begin
            res_x     <= fin.x;
            res_y     <= fin.y;
            res_found <= 1'b1;
            state     <= S_FIN;
          end else begin
            seg_i <= '0;
            hit   <= 1'b0;
            state <= S_SEG;
          end
        end
        S_SEG: begin
          if (seg_i + 1'b1 >= cnt) begin
            state <= S_DROP;
          end else begin
            rd_addr <= head + seg_i[ppt_pkg::ADDR_W-1:0];
            state   <= S_P1W;
          end
        end
        S_P1W: begin
          rd_addr <= rd_addr + 1'b1;
          state   <= S_P1C;
        end
        S_P1C: begin
          x1    <= {mem_rdata.x[ppt_pkg::COORD_BITS-1], mem_rdata.x};
          y1    <= {mem_rdata.y[ppt_pkg::COORD_BITS-1], mem_rdata.y};
          state <= S_P2C;
        end
        S_P2C: begin
          dx    <= {mem_rdata.x[ppt_pkg::COORD_BITS-1], mem_rdata.x} - x1;
          dy    <= {mem_rdata.y[ppt_pkg::COORD_BITS-1], mem_rdata.y} - y1;
          state <= S_A1;
        end
        S_A1: state <= S_A2;
        S_A2: begin
          acc   <= prod;
          state <= S_A3;
        end
        S_A3: begin
          acc   <= acc + prod;
          state <= S_A4;
        end
        S_A4: state <= (acc == '0) ? S_NEXT : S_LEN;
        S_LEN: begin
          if (ds_done) begin
            len   <= ds_res[ppt_pkg::ROOT_W-1:0];
            state <= S_D1;
          end
        end
        S_D1: state <= S_D2;
        S_D2: begin
          acc   <= prod;
          state <= S_D3;
        end
        S_D3: begin
          dot   <= acc + prod;
          state <= S_D4;
        end
        S_D4: begin
          acc   <= prod;
          state <= S_D5;
        end
        S_D5: state <= S_DIST;
        S_DIST: begin
          if (ds_done) begin
            if (ds_res > ppt_pkg::NUM_W'(r_rad)) begin
              state <= S_NEXT;
            end else begin
              perp  <= ds_res[ppt_pkg::RAD_W-1:0];
              state <= S_DT1;
            end
          end
        end
        S_DT1: state <= S_DT2;
        S_DT2: state <= S_LL;
        S_LL: begin
          if (ds_done) begin
            ll    <= ds_res[ppt_pkg::RAD_W-1:0];
            state <= S_S0;
          end
        end
        S_S0: begin
          if (ds_done) begin
            if (ok_a) begin
              s     <= sa[ppt_pkg::ROOT_W-1:0];
              state <= S_X1;
            end else if (ok_b) begin
              s     <= sb[ppt_pkg::ROOT_W-1:0];
              state <= S_X1;
            end else begin
              state <= S_NEXT;
            end
          end
        end
        S_X1: state <= S_X2;
        S_X2: begin
          negq  <= prod[ppt_pkg::PROD_W-1];
          state <= S_XQ;
        end
        S_XQ: begin
          if (ds_done) begin
            hx    <= ppt_pkg::COORD_BITS'({x1[ppt_pkg::DW-1], x1} + hsum);
            state <= S_Y1;
          end
        end
        S_Y1: state <= S_Y2;
        S_Y2: begin
          negq  <= prod[ppt_pkg::PROD_W-1];
          state <= S_YQ;
        end
        S_YQ: begin
          if (ds_done) begin
            res_x     <= hx;
            res_y     <= ppt_pkg::COORD_BITS'({y1[ppt_pkg::DW-1], y1} + hsum);
            res_found <= 1'b1;
            hit       <= 1'b1;
            chosen    <= seg_i[ppt_pkg::ADDR_W-1:0];
            state     <= S_NEXT;
          end
        end
        S_NEXT: begin
          seg_i <= seg_i + 1'b1;
          state <= S_SEG;
        end
        S_DROP: begin
          if (drop && hit && chosen != '0) begin
            head <= head + chosen;
            cnt  <= cnt - ppt_pkg::CNT_W'(chosen);
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid      <= 1'b1;
            target_x       <= res_x;
            target_y       <= res_y;
            target_found   <= res_found;
            at_goal        <= goal;
            status         <= res_status;
            waypoint_count <= cnt;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for pure_pursuit_target_finder_top: directed table then random
// requests, checked against a behavioral lookahead predictor. Depends on ppt_pkg and the RTL.
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic [1:0] op;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [19:0] h;
    logic turn;
    logic drop;
  } req_t;

  typedef struct packed {
    logic signed [23:0] tx;
    logic signed [23:0] ty;
    logic found;
    logic goal;
    logic [1:0] st;
    logic [6:0] cnt;
  } res_t;

  typedef struct {
    req_t rq;
    logic has_exp;
    res_t ex;
  } row_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, is_turn = 0, drop_passed = 0;
  logic [1:0] opcode = 0;
  logic signed [23:0] pos_x = 0, pos_y = 0;
  logic signed [19:0] heading = 0;
  logic out_valid, out_ready = 0, target_found, at_goal;
  logic signed [23:0] target_x, target_y;
  logic [1:0] status;
  logic [6:0] waypoint_count;
  logic psel = 0, penable = 0, pwrite = 0, pready;
  logic [3:0] paddr = 0;
  logic [31:0] pwdata = 0, prdata;

  pure_pursuit_target_finder_top dut (.*);

  longint wx[64], wy[64], wh[64];
  bit wt[64];
  int unsigned head_ix, count;
  longint radius, ptol, htol;
  res_t expected_q[$];
  row_t tbl[$];
  int errors = 0;
  int send_idle = 25, recv_idle = 88;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000000;
    $display("pure_pursuit_target_finder_top regression: fail");
    $finish;
  end

  function automatic longint isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint labs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit segment_hit(longint x1, longint y1, longint x2, longint y2,
                                     longint cx, longint cy, output longint ox,
                                     output longint oy);
    longint dx, dy, a, len, fx, fy, dt, cr, perp, ll, s0, s;
    dx = x2 - x1;
    dy = y2 - y1;
    a = dx * dx + dy * dy;
    ox = 0;
    oy = 0;
    if (a == 0) return 0;
    len = isqrt(a);
    fx = x1 - cx;
    fy = y1 - cy;
    dt = fx * dx + fy * dy;
    cr = fx * dy - fy * dx;
    perp = labs(cr) / len;
    if (perp > radius) return 0;
    ll = isqrt(radius * radius - perp * perp);
    s0 = -(dt / len);
    s = s0 + ll;
    if (s < 0 || s > len) begin
      s = s0 - ll;
      if (s < 0 || s > len) return 0;
    end
    ox = x1 + (dx * s) / len;
    oy = y1 + (dy * s) / len;
    return 1;
  endfunction

  function automatic res_t predict_target(req_t rq);
    res_t r;
    int unsigned k, fk, k1, k2, i;
    longint fx, fy, ex, ey, hx, hy;
    int chosen;
    r = '{default: 0};
    if (rq.op == ppt_pkg::OP_LOAD) begin
      head_ix = 0;
      count = 1;
      wx[0] = rq.x;
      wy[0] = rq.y;
      wh[0] = rq.h;
      wt[0] = rq.turn;
    end else if (rq.op == ppt_pkg::OP_APPEND) begin
      if (count >= 64) begin
        r.st = ppt_pkg::ST_FULL;
      end else begin
        k = (head_ix + count) % 64;
        wx[k] = rq.x;
        wy[k] = rq.y;
        wh[k] = rq.h;
        wt[k] = rq.turn;
        count++;
      end
    end else if (rq.op == ppt_pkg::OP_QUERY) begin
      if (count == 0) begin
        r.st = ppt_pkg::ST_EMPTY;
      end else begin
        fk = (head_ix + count - 1) % 64;
        fx = wx[fk];
        fy = wy[fk];
        ex = rq.x - fx;
        ey = rq.y - fy;
        if (ex * ex + ey * ey < radius * radius) begin
          r.tx = 24'(fx);
          r.ty = 24'(fy);
          r.found = 1'b1;
        end else begin
          chosen = -1;
          for (i = 0; i + 1 < count; i++) begin
            k1 = (head_ix + i) % 64;
            k2 = (head_ix + i + 1) % 64;
            if (segment_hit(wx[k1], wy[k1], wx[k2], wy[k2], rq.x, rq.y, hx, hy)) begin
              r.tx = 24'(hx);
              r.ty = 24'(hy);
              r.found = 1'b1;
              chosen = i;
            end
          end
          if (rq.drop && chosen > 0) begin
            head_ix = (head_ix + chosen) % 64;
            count -= chosen;
          end
        end
        fk = (head_ix + count - 1) % 64;
        r.goal = labs(wx[fk] - rq.x) < ptol && labs(wy[fk] - rq.y) < ptol &&
                 (!wt[fk] || labs(wh[fk] - rq.h) < htol);
      end
    end
    r.cnt = 7'(count);
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      ppt_pkg::REG_RADIUS: radius = val & 32'h7FFFFF;
      ppt_pkg::REG_PTOL:   ptol = val & 32'h7FFFFF;
      default:             htol = val & 32'h7FFFF;
    endcase
  endtask

  task automatic send_request(req_t rq, bit has_exp, res_t ex);
    res_t p;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) @(negedge clk);
    in_valid <= 1;
    opcode <= rq.op;
    pos_x <= rq.x;
    pos_y <= rq.y;
    heading <= rq.h;
    is_turn <= rq.turn;
    drop_passed <= rq.drop;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = predict_target(rq);
    if (has_exp && p != ex) begin
      $error("table row disagrees with predictor");
      errors++;
    end
    expected_q.insert(expected_q.size(), p);
    @(negedge clk);
    in_valid <= 0;
  endtask

  task automatic drain_results();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    res_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = expected_q[0];
        expected_q.delete(0);
        if (target_x !== e.tx) begin
          $error("target_x exp %0d got %0d", e.tx, target_x); errors++;
        end
        if (target_y !== e.ty) begin
          $error("target_y exp %0d got %0d", e.ty, target_y); errors++;
        end
        if (target_found !== e.found) begin
          $error("target_found exp %0d got %0d", e.found, target_found); errors++;
        end
        if (at_goal !== e.goal) begin
          $error("at_goal exp %0d got %0d", e.goal, at_goal); errors++;
        end
        if (status !== e.st) begin
          $error("status exp %0d got %0d", e.st, status); errors++;
        end
        if (waypoint_count !== e.cnt) begin
          $error("waypoint_count exp %0d got %0d", e.cnt, waypoint_count); errors++;
        end
      end
    end
  end

  function automatic req_t mk(logic [1:0] op, longint x, longint y, longint h, bit t, bit d);
    req_t r;
    r.op = op; r.x = 24'(x); r.y = 24'(y); r.h = 20'(h); r.turn = t; r.drop = d;
    return r;
  endfunction

  function automatic res_t rs(longint tx, longint ty, bit f, bit g, logic [1:0] st, int c);
    res_t r;
    r.tx = 24'(tx); r.ty = 24'(ty); r.found = f; r.goal = g; r.st = st; r.cnt = 7'(c);
    return r;
  endfunction

  function automatic void add_row(req_t rq, bit has_exp, res_t ex);
    tbl.insert(tbl.size(), '{rq, has_exp, ex});
  endfunction

  function automatic req_t random_request(int span);
    req_t r;
    int c;
    c = $urandom_range(99);
    r.op = c < 8 ? ppt_pkg::OP_LOAD : c < 55 ? ppt_pkg::OP_APPEND :
           c < 97 ? ppt_pkg::OP_QUERY : ppt_pkg::OP_RSVD;
    if ($urandom_range(9) == 0) begin
      r.x = 24'($urandom);
      r.y = 24'($urandom);
    end else begin
      r.x = 24'($signed($urandom_range(2 * span)) - span);
      r.y = 24'($signed($urandom_range(2 * span)) - span);
    end
    r.h = 20'($urandom);
    r.turn = 1'($urandom);
    r.drop = 1'($urandom);
    return r;
  endfunction

  initial begin
    res_t z;
    int n, i;
    z = '{default: 0};
    head_ix = 0;
    count = 0;
    radius = ppt_pkg::RAD_RESET;
    ptol = ppt_pkg::PTOL_RESET;
    htol = ppt_pkg::HTOL_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    add_row(mk(ppt_pkg::OP_QUERY, 0, 0, 0, 0, 0), 1, rs(0, 0, 0, 0, ppt_pkg::ST_EMPTY, 0));
    add_row(mk(ppt_pkg::OP_LOAD, 0, 0, 0, 1, 0), 1, rs(0, 0, 0, 0, ppt_pkg::ST_OK, 1));
    add_row(mk(ppt_pkg::OP_QUERY, 0, 0, 0, 0, 0), 1, rs(0, 0, 1, 1, ppt_pkg::ST_OK, 1));
    add_row(mk(ppt_pkg::OP_QUERY, 0, 0, 524287, 0, 0), 1,
            rs(0, 0, 1, 0, ppt_pkg::ST_OK, 1));
    add_row(mk(ppt_pkg::OP_RSVD, -8388608, 8388607, -524288, 1, 1), 1,
            rs(0, 0, 0, 0, ppt_pkg::ST_OK, 1));
    add_row(mk(ppt_pkg::OP_APPEND, 196608, 0, 0, 0, 0), 1,
            rs(0, 0, 0, 0, ppt_pkg::ST_OK, 2));
    add_row(mk(ppt_pkg::OP_APPEND, 196608, 196608, 0, 0, 0), 1,
            rs(0, 0, 0, 0, ppt_pkg::ST_OK, 3));
    add_row(mk(ppt_pkg::OP_QUERY, 65536, 0, 0, 0, 0), 0, z);
    add_row(mk(ppt_pkg::OP_QUERY, 196608, 65536, 0, 0, 1), 0, z);
    add_row(mk(ppt_pkg::OP_QUERY, 196608, 196608, 0, 0, 0), 1,
            rs(196608, 196608, 1, 1, ppt_pkg::ST_OK, 2));
    add_row(mk(ppt_pkg::OP_QUERY, 8388607, 8388607, 0, 0, 1), 1,
            rs(0, 0, 0, 0, ppt_pkg::ST_OK, 2));
    add_row(mk(ppt_pkg::OP_LOAD, 8388607, -8388608, 524287, 0, 0), 1,
            rs(0, 0, 0, 0, ppt_pkg::ST_OK, 1));
    add_row(mk(ppt_pkg::OP_APPEND, 8388607, -8388608, -524288, 1, 0), 0, z);
    add_row(mk(ppt_pkg::OP_QUERY, -8388608, 8388607, -524288, 1, 1), 0, z);
    foreach (tbl[k]) send_request(tbl[k].rq, tbl[k].has_exp, tbl[k].ex);
    drain_results();

    // Fill the store to capacity, then one append past it.
    send_request(mk(ppt_pkg::OP_LOAD, 0, 0, 0, 0, 0), 0, z);
    for (i = 1; i < 64; i++) begin
      send_request(mk(ppt_pkg::OP_APPEND, i * 32768, (i % 2) * 16384, 0, 0, 0), 0, z);
    end
    send_request(mk(ppt_pkg::OP_APPEND, 0, 0, 0, 0, 0), 1,
                 rs(0, 0, 0, 0, ppt_pkg::ST_FULL, 64));
    send_request(mk(ppt_pkg::OP_QUERY, 1000000, 0, 0, 0, 1), 0, z);
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 25 : ph == 1 ? 88 : 0;
      recv_idle = ph == 0 ? 88 : ph == 1 ? 25 : 0;
      write_reg(ppt_pkg::REG_RADIUS,
                ph == 0 ? 0 : ph == 1 ? 32'h7FFFFF : $urandom_range(300000, 30000));
      write_reg(ppt_pkg::REG_PTOL, ph == 0 ? 32'h7FFFFF : ph == 1 ? 0 : $urandom_range(40000));
      write_reg(ppt_pkg::REG_HTOL, ph == 0 ? 0 : ph == 1 ? 32'h7FFFF : $urandom_range(40000));
      for (n = 0; n < 20; n++) begin
        send_request(random_request(ph == 1 ? 8388607 : 400000), 0, z);
        if (n == 10) drain_results();
      end
      drain_results();
    end
    if (errors == 0) begin
      $display("pure_pursuit_target_finder_top regression: pass");
    end else begin
      $display("pure_pursuit_target_finder_top regression: fail");
    end
    $finish;
  end

endmodule
